[sv/ose_pkg.sv]
// ose_pkg: shared types and constants for the operand stack engine.
// Used by ose_ctrl, ose_dpath and operand_stack_engine. No dependencies.
package ose_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int MIN_SWAP        = 2;

  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 7;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 8;

  localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SWAP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DUP   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FEW       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADIDX    = 3'd4;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_PUSH,
    WR_DUP,
    WR_SWAP_HI,
    WR_SWAP_LO
  } wr_op_t;

  typedef enum logic [1:0] {
    FILL_HOLD,
    FILL_INC,
    FILL_DEC,
    FILL_CLR
  } fill_op_t;

  typedef struct packed {
    logic                load;
    logic                rd_en;
    logic                rd_peek;
    wr_op_t              wr_op;
    fill_op_t            fill_op;
    logic                emit;
    logic                emit_read;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic few;
    logic idx_bad;
  } sts_t;

endpackage

[sv/ose_dpath.sv]
// ose_dpath: stack memory, fill count, operand and result registers.
// Driven by ose_ctrl commands; uses ose_pkg.
module ose_dpath #(
  parameter int STACK_DEPTH = ose_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ose_pkg::cmd_t                       cmd,
  output ose_pkg::sts_t                       sts,
  input  logic signed [ose_pkg::VALUE_W-1:0]  in_push_value,
  input  logic [ose_pkg::INDEX_W-1:0]         in_peek_index,
  output logic                                out_strobe,
  output logic [ose_pkg::STATUS_W-1:0]        out_status,
  output logic signed [ose_pkg::VALUE_W-1:0]  out_read_value,
  output logic [ose_pkg::DEPTH_W-1:0]         out_depth_after
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int CW = FW + ose_pkg::INDEX_W;
  localparam int XW = FW + ose_pkg::DEPTH_W;
  localparam int IX = AW + ose_pkg::INDEX_W;

  logic [ose_pkg::VALUE_W-1:0] mem [STACK_DEPTH];

  logic [FW-1:0]                       fill_r, fill_nxt;
  logic signed [ose_pkg::VALUE_W-1:0]  value_r;
  logic [ose_pkg::INDEX_W-1:0]         idx_r;
  logic [ose_pkg::VALUE_W-1:0]         rd_a_r, rd_b_r;
  logic                                strobe_r;
  logic [ose_pkg::STATUS_W-1:0]        status_r;
  logic signed [ose_pkg::VALUE_W-1:0]  read_r;
  logic [ose_pkg::DEPTH_W-1:0]         depth_r;

  logic [FW-1:0]               top_f, second_f;
  logic [AW-1:0]               addr_next, addr_top, addr_second, addr_idx, addr_a;
  logic [IX-1:0]               idx_ext;
  logic [XW-1:0]               depth_ext;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [ose_pkg::VALUE_W-1:0] wr_data;

  assign top_f       = fill_r - FW'(1);
  assign second_f    = fill_r - FW'(ose_pkg::MIN_SWAP);
  assign addr_next   = fill_r[AW-1:0];
  assign addr_top    = top_f[AW-1:0];
  assign addr_second = second_f[AW-1:0];
  assign idx_ext     = IX'(idx_r);
  assign addr_idx    = idx_ext[AW-1:0];
  assign addr_a      = cmd.rd_peek ? addr_idx : addr_top;

  assign sts.empty   = (fill_r == '0);
  assign sts.full    = (fill_r == FW'(STACK_DEPTH));
  assign sts.few     = (fill_r < FW'(ose_pkg::MIN_SWAP));
  assign sts.idx_bad = (CW'(idx_r) >= CW'(fill_r));

  always_comb begin
    fill_nxt = fill_r;
    case (cmd.fill_op)
      ose_pkg::FILL_INC: fill_nxt = fill_r + FW'(1);
      ose_pkg::FILL_DEC: fill_nxt = top_f;
      ose_pkg::FILL_CLR: fill_nxt = '0;
      default:           fill_nxt = fill_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = addr_next;
    wr_data = value_r;
    unique case (cmd.wr_op)
      ose_pkg::WR_PUSH: begin
        wr_addr = addr_next;
        wr_data = value_r;
      end
      ose_pkg::WR_DUP: begin
        wr_addr = addr_next;
        wr_data = rd_a_r;
      end
      ose_pkg::WR_SWAP_HI: begin
        wr_addr = addr_top;
        wr_data = rd_b_r;
      end
      ose_pkg::WR_SWAP_LO: begin
        wr_addr = addr_second;
        wr_data = rd_a_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign depth_ext = XW'(fill_nxt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_second];
    end
    if (cmd.load) begin
      value_r <= in_push_value;
      idx_r   <= in_peek_index;
    end
    if (cmd.emit) begin
      status_r <= cmd.status;
      read_r   <= cmd.emit_read ? rd_a_r : '0;
      depth_r  <= depth_ext[ose_pkg::DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      strobe_r <= cmd.emit;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_read_value  = read_r;
  assign out_depth_after = depth_r;

endmodule

[sv/ose_ctrl.sv]
// ose_ctrl: request sequencer for the operand stack engine.
// Issues ose_pkg::cmd_t to ose_dpath and reads back its ose_pkg::sts_t.
module ose_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ose_pkg::MODE_W-1:0]  in_mode,
  output logic                        busy,
  input  ose_pkg::sts_t               sts,
  output ose_pkg::cmd_t               cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH,
    S_SWAP_HI,
    S_SWAP_LO,
    S_DUP_WR
  } state_t;

  state_t                     state_r, state_nxt;
  logic [ose_pkg::MODE_W-1:0] mode_r, mode_nxt;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cmd.load      = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.rd_peek   = 1'b0;
    cmd.wr_op     = ose_pkg::WR_NONE;
    cmd.fill_op   = ose_pkg::FILL_HOLD;
    cmd.emit      = 1'b0;
    cmd.emit_read = 1'b0;
    cmd.status    = ose_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          mode_nxt  = in_mode;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (mode_r)
          ose_pkg::MODE_PUSH: begin
            cmd.emit = 1'b1;
            if (sts.full) begin
              cmd.status = ose_pkg::ST_OVERFLOW;
            end else begin
              cmd.wr_op   = ose_pkg::WR_PUSH;
              cmd.fill_op = ose_pkg::FILL_INC;
            end
          end
          ose_pkg::MODE_POP: begin
            if (sts.empty) begin
              cmd.emit   = 1'b1;
              cmd.status = ose_pkg::ST_UNDERFLOW;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.fill_op = ose_pkg::FILL_DEC;
              state_nxt   = S_FINISH;
            end
          end
          ose_pkg::MODE_PEEK: begin
            if (sts.empty) begin
              cmd.emit   = 1'b1;
              cmd.status = ose_pkg::ST_UNDERFLOW;
            end else if (sts.idx_bad) begin
              cmd.emit   = 1'b1;
              cmd.status = ose_pkg::ST_BADIDX;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_peek = 1'b1;
              state_nxt   = S_FINISH;
            end
          end
          ose_pkg::MODE_SWAP: begin
            if (sts.few) begin
              cmd.emit   = 1'b1;
              cmd.status = ose_pkg::ST_FEW;
            end else begin
              cmd.rd_en = 1'b1;
              state_nxt = S_SWAP_HI;
            end
          end
          ose_pkg::MODE_DUP: begin
            if (sts.empty) begin
              cmd.emit   = 1'b1;
              cmd.status = ose_pkg::ST_UNDERFLOW;
            end else if (sts.full) begin
              cmd.emit   = 1'b1;
              cmd.status = ose_pkg::ST_OVERFLOW;
            end else begin
              cmd.rd_en = 1'b1;
              state_nxt = S_DUP_WR;
            end
          end
          ose_pkg::MODE_CLEAR: begin
            cmd.emit    = 1'b1;
            cmd.fill_op = ose_pkg::FILL_CLR;
          end
          default: cmd.emit = 1'b1;
        endcase
      end
      S_FINISH: begin
        cmd.emit      = 1'b1;
        cmd.emit_read = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SWAP_HI: begin
        cmd.wr_op = ose_pkg::WR_SWAP_HI;
        state_nxt = S_SWAP_LO;
      end
      S_SWAP_LO: begin
        cmd.wr_op = ose_pkg::WR_SWAP_LO;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DUP_WR: begin
        cmd.wr_op   = ose_pkg::WR_DUP;
        cmd.fill_op = ose_pkg::FILL_INC;
        cmd.emit    = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= ose_pkg::MODE_PUSH;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[sv/operand_stack_engine.sv]
// operand_stack_engine: LIFO stack of signed 32-bit values with push, pop, peek,
// swap, dup and clear. Push, clear and failed requests emit from the execute state;
// pop and peek add a finish state, dup a write state and swap two write states
// (two writes through the single memory write port). The result is registered from
// the last state; busy is low when the next request can be taken. Sync active-low reset
// empties the stack; entries themselves are not cleared. The result receiver cannot stall.
module operand_stack_engine #(
  parameter int STACK_DEPTH = ose_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ose_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [ose_pkg::VALUE_W-1:0]  in_push_value,
  input  logic [ose_pkg::INDEX_W-1:0]         in_peek_index,
  output logic                                out_strobe,
  output logic [ose_pkg::STATUS_W-1:0]        out_status,
  output logic signed [ose_pkg::VALUE_W-1:0]  out_read_value,
  output logic [ose_pkg::DEPTH_W-1:0]         out_depth_after
);

  ose_pkg::cmd_t cmd;
  ose_pkg::sts_t sts;

  ose_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .busy    (busy),
    .sts     (sts),
    .cmd     (cmd)
  );

  ose_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_push_value   (in_push_value),
    .in_peek_index   (in_peek_index),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_depth_after (out_depth_after)
  );

endmodule
